// ----- rtl/qpd_pkg.sv -----
package qpd_pkg;

  // Command codes carried by each input word.
  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_DRIVE_ABS = 2'd1,
    CMD_DRIVE_REL = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

  // Direction of a pending drive.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  localparam int unsigned PosW   = 32;
  localparam int unsigned PowerW = 8;
  localparam logic [PowerW-2:0] PowerMax = '1;

  // Input word.
  typedef struct packed {
    logic [1:0]             command;
    logic                   pin_a;
    logic                   pin_b;
    logic signed [PosW-1:0] drive_value;
    logic [PowerW-1:0]      drive_power;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [PosW-1:0]   position;
    logic signed [PowerW-1:0] motor_power;
    logic                     target_reached;
    logic [PosW-1:0]          edge_period;
    logic                     drive_active;
  } out_word_t;

  // Request from the position datapath to the drive control.
  typedef struct packed {
    logic                   count_en;
    logic                   start_en;
    logic signed [PosW-1:0] pos_cur;
    logic signed [PosW-1:0] pos_counted;
    logic signed [PosW-1:0] start_target;
    logic [PowerW-1:0]      power_raw;
  } drive_req_t;

  // Drive status after the current word.
  typedef struct packed {
    logic                     reached;
    logic                     active;
    logic signed [PowerW-1:0] power;
  } drive_stat_t;

endpackage

// ----- rtl/quadrature_position_drive.sv -----
// A word passes through the input register and then the result register.
// Throughput: one word per cycle while downstream does not stall (out_stall_i).
// The input register and the result register each hold one word.
// Reset (rst_ni, asynchronous, active low) clears position, pin history, tick count,
// period and the pending drive, and empties both registers.
module quadrature_position_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qpd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qpd_pkg::out_word_t out_word_o
);

  qpd_pkg::in_word_t                in_word_q;
  logic                             in_vld_q;
  qpd_pkg::out_word_t               out_word_q, out_word_d;
  logic                             out_vld_q;
  logic signed [qpd_pkg::PosW-1:0]  pos_q, pos_d, pos_counted;
  logic                             prev_a_q, prev_b_q;
  logic [qpd_pkg::PosW-1:0]         tick_q, tick_d, last_q, last_d, period_q, period_d;
  logic signed [2:0]                delta;
  logic                             advance, proc, sample, counting;
  qpd_pkg::drive_req_t              req;
  qpd_pkg::drive_stat_t             stat;

  // The pipeline moves when the result register is empty or being taken.
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign proc       = in_vld_q && advance;
  assign sample     = proc && (in_word_q.command == qpd_pkg::CMD_SAMPLE);
  assign counting   = sample && (delta != 3'sd0);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  qpd_decoder u_decoder (
    .pin_a_i  (in_word_q.pin_a),
    .pin_b_i  (in_word_q.pin_b),
    .prev_a_i (prev_a_q),
    .prev_b_i (prev_b_q),
    .delta_o  (delta)
  );

  assign pos_counted = pos_q + {{(qpd_pkg::PosW-3){delta[2]}}, delta};

  // Position, tick and period update.
  always_comb begin
    pos_d    = pos_q;
    tick_d   = tick_q;
    last_d   = last_q;
    period_d = period_q;
    if (sample) begin
      tick_d = tick_q + 1'b1;
    end
    if (counting) begin
      pos_d    = pos_counted;
      period_d = tick_d - last_q;
      last_d   = tick_d;
    end
    if (proc && (in_word_q.command == qpd_pkg::CMD_CLEAR)) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      prev_a_q <= 1'b0;
      prev_b_q <= 1'b0;
      tick_q   <= '0;
      last_q   <= '0;
      period_q <= '0;
    end else begin
      pos_q  <= pos_d;
      tick_q <= tick_d;
      last_q <= last_d;
      period_q <= period_d;
      if (sample) begin
        prev_a_q <= in_word_q.pin_a;
        prev_b_q <= in_word_q.pin_b;
      end
    end
  end

  // Drive request for this word.
  always_comb begin
    req.count_en    = counting;
    req.start_en    = proc && ((in_word_q.command == qpd_pkg::CMD_DRIVE_ABS) ||
                               (in_word_q.command == qpd_pkg::CMD_DRIVE_REL));
    req.pos_cur     = pos_q;
    req.pos_counted = pos_counted;
    req.start_target = (in_word_q.command == qpd_pkg::CMD_DRIVE_REL)
                       ? pos_q + in_word_q.drive_value : in_word_q.drive_value;
    req.power_raw   = in_word_q.drive_power;
  end

  qpd_drive_ctrl u_drive (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .stat_o (stat)
  );

  // Result word from the state after this word.
  always_comb begin
    out_word_d.position       = pos_d;
    out_word_d.motor_power    = stat.power;
    out_word_d.target_reached = stat.reached;
    out_word_d.edge_period    = period_d;
    out_word_d.drive_active   = stat.active;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/qpd_decoder.sv -----
module qpd_decoder (
  input  logic              pin_a_i,
  input  logic              pin_b_i,
  input  logic              prev_a_i,
  input  logic              prev_b_i,
  output logic signed [2:0] delta_o
);

  logic signed [2:0] delta_a;
  logic signed [2:0] delta_b;

  // An edge on A counts up when A now differs from the prior B.
  always_comb begin
    delta_a = 3'sd0;
    if (pin_a_i != prev_a_i) begin
      delta_a = (pin_a_i != prev_b_i) ? 3'sd1 : -3'sd1;
    end
  end

  // An edge on B counts up when B now equals the prior A.
  always_comb begin
    delta_b = 3'sd0;
    if (pin_b_i != prev_b_i) begin
      delta_b = (pin_b_i == prev_a_i) ? 3'sd1 : -3'sd1;
    end
  end

  assign delta_o = delta_a + delta_b;

endmodule

// ----- rtl/qpd_drive_ctrl.sv -----
module qpd_drive_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qpd_pkg::drive_req_t req_i,
  output qpd_pkg::drive_stat_t stat_o
);

  logic signed [qpd_pkg::PosW-1:0]   target_q, target_d;
  qpd_pkg::dir_e                     dir_q, dir_d;
  logic signed [qpd_pkg::PowerW-1:0] power_q, power_d;
  logic                              drive_on;
  logic                              hit;
  logic [qpd_pkg::PowerW-2:0]        mag;
  logic                              reached;

  assign drive_on = (dir_q == qpd_pkg::DIR_UP) || (dir_q == qpd_pkg::DIR_DOWN);

  // Target test on the position after decoding.
  always_comb begin
    case (dir_q)
      qpd_pkg::DIR_UP:   hit = req_i.pos_counted >= target_q;
      qpd_pkg::DIR_DOWN: hit = req_i.pos_counted <= target_q;
      default:           hit = 1'b0;
    endcase
  end

  // Power magnitude saturates at the largest positive code.
  assign mag = req_i.power_raw[qpd_pkg::PowerW-1] ? qpd_pkg::PowerMax
                                                  : req_i.power_raw[qpd_pkg::PowerW-2:0];

  // Next drive state: completion on counting words, start on drive words.
  always_comb begin
    target_d = target_q;
    dir_d    = dir_q;
    power_d  = power_q;
    reached  = 1'b0;
    if (req_i.count_en && hit) begin
      dir_d   = qpd_pkg::DIR_NONE;
      power_d = '0;
      reached = 1'b1;
    end
    if (req_i.start_en && (req_i.power_raw != '0) &&
        (req_i.start_target != req_i.pos_cur)) begin
      reached  = drive_on;
      target_d = req_i.start_target;
      if (req_i.start_target > req_i.pos_cur) begin
        dir_d   = qpd_pkg::DIR_UP;
        power_d = {1'b0, mag};
      end else begin
        dir_d   = qpd_pkg::DIR_DOWN;
        power_d = '0 - {1'b0, mag};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      dir_q    <= qpd_pkg::DIR_NONE;
      power_q  <= '0;
    end else begin
      target_q <= target_d;
      dir_q    <= dir_d;
      power_q  <= power_d;
    end
  end

  assign stat_o.reached = reached;
  assign stat_o.active  = (dir_d == qpd_pkg::DIR_UP) || (dir_d == qpd_pkg::DIR_DOWN);
  assign stat_o.power   = power_d;

endmodule
